/* src/assert_macros.svh */
// assertion macros shared by the merge sort block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge outside reset
`define MSIC_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define MSIC_ASSERT_NEXT(name, trig, cond, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

/* src/msic_pkg.sv */
// shared types and constants of the merge sort inversion counter
package msic_pkg;

    localparam int MAX_ELEMENTS_DEF = 64;
    localparam int VALUE_WIDTH_DEF  = 32;
    localparam int ELEM_W           = 32;
    localparam int INV_W            = 11;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SEG_START,
        ST_MERGE,
        ST_EMIT_READ,
        ST_EMIT_SHOW
    } state_t;

    // bank write enables and which bank is the current merge source
    typedef struct packed {
        logic bank0_we;
        logic bank1_we;
        logic src_sel;
    } ram_ctl_t;

endpackage

/* src/msic_ram.sv */
// element bank: one write port, two registered read ports
module msic_ram #(
    parameter int DEPTH  = msic_pkg::MAX_ELEMENTS_DEF,
    parameter int DATA_W = msic_pkg::VALUE_WIDTH_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [AW-1:0]     raddr_a,
    input  logic [AW-1:0]     raddr_b,
    output logic [DATA_W-1:0] rdata_a,
    output logic [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_a_reg;
    logic [DATA_W-1:0] rdata_b_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read ports, registered
    always_ff @(posedge aclk) begin
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

/* src/msic_seq.sv */
// sequencer: load, bottom-up merge passes between two banks, emit
module msic_seq #(
    parameter int MAX_ELEMENTS = msic_pkg::MAX_ELEMENTS_DEF,
    parameter int VALUE_WIDTH  = msic_pkg::VALUE_WIDTH_DEF,
    localparam int AW          = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1,
    localparam int CW          = $clog2(MAX_ELEMENTS + 1),
    localparam int SW          = CW + 1
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [msic_pkg::ELEM_W-1:0] s_element_value,
    input  logic                             s_last_element,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_run_end,
    output logic [msic_pkg::INV_W-1:0]       m_inversion_total,
    output logic                             m_overflowed,
    output msic_pkg::ram_ctl_t               ctl,
    output logic [AW-1:0]                    waddr,
    output logic [VALUE_WIDTH-1:0]           wdata,
    output logic [AW-1:0]                    raddr_a,
    output logic [AW-1:0]                    raddr_b,
    input  logic [VALUE_WIDTH-1:0]           rdata_a,
    input  logic [VALUE_WIDTH-1:0]           rdata_b
);

    msic_pkg::state_t state_reg, state_next;

    logic [CW-1:0]              count_reg, count_next;
    logic [msic_pkg::INV_W-1:0] inv_reg, inv_next;
    logic                       ovf_reg, ovf_next;
    logic                       src_sel_reg, src_sel_next;
    logic [CW-1:0]              width_reg, width_next;
    logic [CW-1:0]              lo_reg, lo_next;
    logic [CW-1:0]              mid_reg, mid_next;
    logic [CW-1:0]              hi_reg, hi_next;
    logic [CW-1:0]              i_reg, i_next;
    logic [CW-1:0]              j_reg, j_next;
    logic [CW-1:0]              k_reg, k_next;

    logic [VALUE_WIDTH-1:0] load_value;
    logic [SW-1:0]          n_ext;
    logic [SW-1:0]          lo_plus_w;
    logic [SW-1:0]          lo_plus_2w;
    logic [SW-1:0]          width_x2;
    logic [CW-1:0]          mid_c;
    logic [CW-1:0]          hi_c;
    logic                   a_live;
    logic                   b_live;
    logic                   take_b;
    logic [CW-1:0]          k_inc;

    // input value narrowed or sign-extended to the stored width
    generate
        if (VALUE_WIDTH <= msic_pkg::ELEM_W) begin : g_narrow
            assign load_value = s_element_value[VALUE_WIDTH-1:0];
        end else begin : g_wide
            assign load_value = {{(VALUE_WIDTH - msic_pkg::ELEM_W){s_element_value[
                msic_pkg::ELEM_W-1]}}, s_element_value};
        end
    endgenerate

    // run bounds of the current segment
    assign n_ext      = {1'b0, count_reg};
    assign lo_plus_w  = {1'b0, lo_reg} + {1'b0, width_reg};
    assign lo_plus_2w = {1'b0, lo_reg} + {width_reg, 1'b0};
    assign width_x2   = {width_reg, 1'b0};
    assign mid_c      = (lo_plus_w > n_ext) ? count_reg : lo_plus_w[CW-1:0];
    assign hi_c       = (lo_plus_2w > n_ext) ? count_reg : lo_plus_2w[CW-1:0];

    // merge choice: right head only when strictly smaller, keeps the sort stable
    assign a_live = (i_reg < mid_reg);
    assign b_live = (j_reg < hi_reg);
    assign take_b = b_live && (!a_live || ($signed(rdata_a) > $signed(rdata_b)));
    assign k_inc  = k_reg + 1'b1;

    // state and counter registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= msic_pkg::ST_LOAD;
            count_reg   <= '0;
            inv_reg     <= '0;
            ovf_reg     <= 1'b0;
            src_sel_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            inv_reg     <= inv_next;
            ovf_reg     <= ovf_next;
            src_sel_reg <= src_sel_next;
        end
    end

    // merge position registers
    always_ff @(posedge aclk) begin
        width_reg <= width_next;
        lo_reg    <= lo_next;
        mid_reg   <= mid_next;
        hi_reg    <= hi_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
    end

    // next state and outputs
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        inv_next     = inv_reg;
        ovf_next     = ovf_reg;
        src_sel_next = src_sel_reg;
        width_next   = width_reg;
        lo_next      = lo_reg;
        mid_next     = mid_reg;
        hi_next      = hi_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;

        s_ready      = 1'b0;
        m_valid      = 1'b0;
        ctl.bank0_we = 1'b0;
        ctl.bank1_we = 1'b0;
        ctl.src_sel  = src_sel_reg;
        waddr        = k_reg[AW-1:0];
        wdata        = take_b ? rdata_b : rdata_a;
        raddr_a      = k_reg[AW-1:0];
        raddr_b      = j_reg[AW-1:0];

        case (state_reg)
            msic_pkg::ST_LOAD: begin
                s_ready = 1'b1;
                waddr   = count_reg[AW-1:0];
                wdata   = load_value;
                if (s_valid) begin
                    if (count_reg < CW'(MAX_ELEMENTS)) begin
                        ctl.bank0_we = 1'b1;
                        count_next   = count_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_last_element) begin
                        width_next = CW'(1);
                        lo_next    = '0;
                        k_next     = '0;
                        if (count_next > CW'(1)) begin
                            state_next = msic_pkg::ST_SEG_START;
                        end else begin
                            state_next = msic_pkg::ST_EMIT_READ;
                        end
                    end
                end
            end

            // prime both read ports with the heads of the two runs
            msic_pkg::ST_SEG_START: begin
                raddr_a    = lo_reg[AW-1:0];
                raddr_b    = mid_c[AW-1:0];
                mid_next   = mid_c;
                hi_next    = hi_c;
                i_next     = lo_reg;
                j_next     = mid_c;
                k_next     = lo_reg;
                state_next = msic_pkg::ST_MERGE;
            end

            // one element into the destination bank per cycle
            msic_pkg::ST_MERGE: begin
                ctl.bank0_we = src_sel_reg;
                ctl.bank1_we = !src_sel_reg;
                if (take_b) begin
                    j_next   = j_reg + 1'b1;
                    inv_next = inv_reg + msic_pkg::INV_W'(mid_reg - i_reg);
                end else begin
                    i_next = i_reg + 1'b1;
                end
                raddr_a = i_next[AW-1:0];
                raddr_b = j_next[AW-1:0];
                k_next  = k_inc;
                if (k_inc == hi_reg) begin
                    state_next = msic_pkg::ST_SEG_START;
                    if (lo_plus_2w >= n_ext) begin
                        src_sel_next = !src_sel_reg;
                        lo_next      = '0;
                        if (width_x2 >= n_ext) begin
                            k_next     = '0;
                            state_next = msic_pkg::ST_EMIT_READ;
                        end else begin
                            width_next = width_x2[CW-1:0];
                        end
                    end else begin
                        lo_next = lo_plus_2w[CW-1:0];
                    end
                end
            end

            msic_pkg::ST_EMIT_READ: begin
                raddr_a    = k_reg[AW-1:0];
                state_next = msic_pkg::ST_EMIT_SHOW;
            end

            // read data register holds the beat until it is taken
            msic_pkg::ST_EMIT_SHOW: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (k_inc == count_reg) begin
                        count_next   = '0;
                        inv_next     = '0;
                        ovf_next     = 1'b0;
                        src_sel_next = 1'b0;
                        state_next   = msic_pkg::ST_LOAD;
                    end else begin
                        k_next  = k_inc;
                        raddr_a = k_inc[AW-1:0];
                    end
                end
            end

            default: begin
                state_next = msic_pkg::ST_LOAD;
            end
        endcase
    end

    assign m_run_end         = (k_inc == count_reg);
    assign m_inversion_total = inv_reg;
    assign m_overflowed      = ovf_reg;

endmodule

/* src/merge_sort_inversion_count_top.sv */
// top level of the merge sort inversion counter
//
// Elements stream in one beat per cycle into bank 0 until the beat marked
// last; at most MAX_ELEMENTS are kept and the rest raise the overflow flag.
// The set is then sorted by bottom-up merge passes that ping-pong between two
// banks, each run pair primed in a segment start state before it is merged.
// The merge speed is set by the single write port of each bank, which takes
// one merged element per cycle. After the first element is read, the sorted
// run leaves one beat per cycle while m_ready is high, each beat carrying
// the inversion total and overflow flag of the whole set. No new element is
// taken while a set is sorted or emitted; counters clear after the final
// beat.
`include "assert_macros.svh"

module merge_sort_inversion_count_top #(
    parameter int MAX_ELEMENTS = msic_pkg::MAX_ELEMENTS_DEF,
    parameter int VALUE_WIDTH  = msic_pkg::VALUE_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [msic_pkg::ELEM_W-1:0] s_element_value,
    input  logic                               s_last_element,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [msic_pkg::ELEM_W-1:0] m_sorted_value,
    output logic                               m_run_end,
    output logic [msic_pkg::INV_W-1:0]         m_inversion_total,
    output logic                               m_overflowed
);

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    msic_pkg::ram_ctl_t     ctl;
    logic [AW-1:0]          waddr;
    logic [VALUE_WIDTH-1:0] wdata;
    logic [AW-1:0]          raddr_a;
    logic [AW-1:0]          raddr_b;
    logic [VALUE_WIDTH-1:0] bank0_a, bank0_b;
    logic [VALUE_WIDTH-1:0] bank1_a, bank1_b;
    logic [VALUE_WIDTH-1:0] src_a, src_b;

    msic_ram #(
        .DEPTH  (MAX_ELEMENTS),
        .DATA_W (VALUE_WIDTH)
    ) u_bank0 (
        .aclk    (aclk),
        .we      (ctl.bank0_we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (bank0_a),
        .rdata_b (bank0_b)
    );

    msic_ram #(
        .DEPTH  (MAX_ELEMENTS),
        .DATA_W (VALUE_WIDTH)
    ) u_bank1 (
        .aclk    (aclk),
        .we      (ctl.bank1_we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (bank1_a),
        .rdata_b (bank1_b)
    );

    // source bank of the current pass, also the result bank when emitting
    assign src_a = ctl.src_sel ? bank1_a : bank0_a;
    assign src_b = ctl.src_sel ? bank1_b : bank0_b;

    msic_seq #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .VALUE_WIDTH  (VALUE_WIDTH)
    ) u_seq (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_element_value   (s_element_value),
        .s_last_element    (s_last_element),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_run_end         (m_run_end),
        .m_inversion_total (m_inversion_total),
        .m_overflowed      (m_overflowed),
        .ctl               (ctl),
        .waddr             (waddr),
        .wdata             (wdata),
        .raddr_a           (raddr_a),
        .raddr_b           (raddr_b),
        .rdata_a           (src_a),
        .rdata_b           (src_b)
    );

    // stored width back to the 32-bit result field
    generate
        if (VALUE_WIDTH >= msic_pkg::ELEM_W) begin : g_cut
            assign m_sorted_value = src_a[msic_pkg::ELEM_W-1:0];
        end else begin : g_ext
            assign m_sorted_value = {{(msic_pkg::ELEM_W - VALUE_WIDTH){src_a[
                VALUE_WIDTH-1]}}, src_a};
        end
    endgenerate

    // a merge writes only the bank it is not reading
    `MSIC_ASSERT_ALWAYS(a_one_bank_write, !(ctl.bank0_we && ctl.bank1_we), "both banks written")
    `MSIC_ASSERT_ALWAYS(a_merge_not_src, !(ctl.bank1_we && ctl.src_sel), "write to source bank")
    // loading and emitting never overlap
    `MSIC_ASSERT_ALWAYS(a_load_emit_apart, !(s_ready && m_valid), "load during emit")
    // the final beat of a run hands the block back to loading
    `MSIC_ASSERT_NEXT(a_end_to_load, m_valid && m_ready && m_run_end, s_ready, "no reload")

endmodule
